// File: sv/mtt_pkg.sv
package mtt_pkg;

    localparam int MAX_DEPTH_DEFAULT = 255;
    localparam int DEPTH_W           = 8;
    localparam int EVENT_W           = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [EVENT_W-1:0] EV_IGNORED  = 4'd0;
    localparam logic [EVENT_W-1:0] EV_OPEN     = 4'd1;
    localparam logic [EVENT_W-1:0] EV_NAME_CH  = 4'd2;
    localparam logic [EVENT_W-1:0] EV_NAME_END = 4'd3;
    localparam logic [EVENT_W-1:0] EV_ANAME_CH = 4'd4;
    localparam logic [EVENT_W-1:0] EV_AVAL_CH  = 4'd5;
    localparam logic [EVENT_W-1:0] EV_ATTR     = 4'd6;
    localparam logic [EVENT_W-1:0] EV_ATTR_TAG = 4'd7;
    localparam logic [EVENT_W-1:0] EV_NAME_TAG = 4'd8;
    localparam logic [EVENT_W-1:0] EV_CLOSE    = 4'd9;
    localparam logic [EVENT_W-1:0] EV_DOC_END  = 4'd10;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW = 4'd11;

    typedef enum logic [10:0] {
        M_START      = 11'b000_0000_0001,
        M_ELEM_START = 11'b000_0000_0010,
        M_ELEM       = 11'b000_0000_0100,
        M_ATTR_NAME  = 11'b000_0000_1000,
        M_VAL_START  = 11'b000_0001_0000,
        M_VAL        = 11'b000_0010_0000,
        M_VAL_END    = 11'b000_0100_0000,
        M_ELEM_END   = 11'b000_1000_0000,
        M_CLOSING    = 11'b001_0000_0000,
        M_END        = 11'b010_0000_0000,
        M_HALT       = 11'b100_0000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [7:0]         ch_out;
        logic [DEPTH_W-1:0] depth;
    } token_req_t;

endpackage

// File: sv/mtt_in_reg.sv
module mtt_in_reg
    import mtt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  byte_req_t byte_req,
    input  logic      advance,
    output logic      hold_valid,
    output byte_req_t hold_req
);

    logic      valid_reg;
    logic      valid_next;
    byte_req_t req_reg;
    logic      load;

    assign byte_stall = valid_reg && !advance;
    assign load       = byte_valid && !byte_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= byte_req;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_req   = req_reg;

endmodule

// File: sv/mtt_scan.sv
module mtt_scan
    import mtt_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  byte_req_t  hold_req,
    output token_req_t result
);

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT =
        DEPTH_W'((MAX_DEPTH < 255) ? MAX_DEPTH : 255);

    scan_mode_t         mode_reg;
    scan_mode_t         mode_next;
    scan_mode_t         mode_step;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] depth_step;
    logic [EVENT_W-1:0] ev;
    logic [7:0]         c;

    assign c = hold_req.ch;

    always_comb
    begin
        mode_step  = mode_reg;
        depth_step = depth_reg;
        ev         = EV_IGNORED;
        case (mode_reg)
            M_START:
            begin
                if (c == CH_LT)
                begin
                    mode_step = M_ELEM_START;
                end
            end
            M_ELEM_START:
            begin
                if (c == CH_SLASH)
                begin
                    if (depth_reg == '0)
                    begin
                        mode_step = M_END;
                        ev        = EV_DOC_END;
                    end
                    else
                    begin
                        depth_step = depth_reg - 1'b1;
                        mode_step  = M_CLOSING;
                        ev         = EV_CLOSE;
                    end
                end
                else if (depth_reg >= DEPTH_LIMIT)
                begin
                    mode_step = M_HALT;
                    ev        = EV_OVERFLOW;
                end
                else
                begin
                    depth_step = depth_reg + 1'b1;
                    mode_step  = M_ELEM;
                    ev         = EV_OPEN;
                end
            end
            M_ELEM:
            begin
                if (c == CH_SPACE)
                begin
                    mode_step = M_ATTR_NAME;
                    ev        = EV_NAME_END;
                end
                else if (c == CH_GT)
                begin
                    mode_step = M_ELEM_END;
                    ev        = EV_NAME_TAG;
                end
                else
                begin
                    ev = EV_NAME_CH;
                end
            end
            M_ATTR_NAME:
            begin
                if (c == CH_EQ)
                begin
                    mode_step = M_VAL_START;
                end
                else
                begin
                    ev = EV_ANAME_CH;
                end
            end
            M_VAL_START:
            begin
                if (c == CH_QUOTE)
                begin
                    mode_step = M_VAL;
                end
            end
            M_VAL:
            begin
                if (c == CH_QUOTE)
                begin
                    mode_step = M_VAL_END;
                end
                else
                begin
                    ev = EV_AVAL_CH;
                end
            end
            M_VAL_END:
            begin
                if (c == CH_SPACE)
                begin
                    mode_step = M_ATTR_NAME;
                    ev        = EV_ATTR;
                end
                else if (c == CH_GT)
                begin
                    mode_step = M_ELEM_END;
                    ev        = EV_ATTR_TAG;
                end
            end
            M_ELEM_END:
            begin
                if (c == CH_LT)
                begin
                    mode_step = M_ELEM_START;
                end
            end
            M_CLOSING:
            begin
                if (c == CH_GT)
                begin
                    mode_step = M_START;
                end
            end
            M_END,
            M_HALT:
            begin
                mode_step = mode_reg;
            end
            default:
            begin
                mode_step = M_START;
            end
        endcase
    end

    // last byte: back to start for the next document
    assign mode_next  = hold_req.last ? M_START : mode_step;
    assign depth_next = hold_req.last ? '0 : depth_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            depth_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
        end
    end

    assign result.event_res = ev;
    assign result.ch_out    = c;
    assign result.depth     = depth_step;

endmodule

// File: sv/mtt_out_reg.sv
module mtt_out_reg
    import mtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hold_valid,
    input  token_req_t result,
    output logic       advance,
    output logic       token_valid,
    input  logic       token_stall,
    output token_req_t token_req
);

    logic       valid_reg;
    logic       valid_next;
    token_req_t req_reg;

    assign advance    = hold_valid && (!valid_reg || !token_stall);
    assign valid_next = advance ? 1'b1 : (token_stall ? valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            req_reg <= result;
        end
    end

    assign token_valid = valid_reg;
    assign token_req   = req_reg;

endmodule

// File: sv/markup_tag_tokenizer_top.sv
// Markup tag tokenizer: scans markup text one byte per request and returns
// one token per byte (event code, the byte itself, nesting depth after it).
// Input channel byte_*: byte_req carries ch and last; accepted when
// byte_valid is high and byte_stall is low.
// Output channel token_*: token_req carries event_res, ch_out and depth;
// taken when token_valid is high and token_stall is low.
// token_valid rises once the accepted byte has passed from the input
// register through the scan logic into the result register.
// Throughput: one byte per cycle while token_stall is low, set by the mode
// and depth update between the input register and the result register.
// A byte with last set is scanned normally; afterwards the scanner returns
// to the start mode with depth 0. An overflow halts the scan until then.
// Reset (rst_n low, asynchronous) empties both registers and puts the
// scanner in the start mode with depth 0.
// When token_stall is high the result register holds its token; the input
// register takes at most one more byte, then byte_stall rises.
module markup_tag_tokenizer_top
    import mtt_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_req_t  byte_req,
    output logic       token_valid,
    input  logic       token_stall,
    output token_req_t token_req
);

    logic       advance;
    logic       hold_valid;
    byte_req_t  hold_req;
    token_req_t result;

    mtt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_req   (byte_req),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_req   (hold_req)
    );

    mtt_scan #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .hold_req (hold_req),
        .result   (result)
    );

    mtt_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold_valid  (hold_valid),
        .result      (result),
        .advance     (advance),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_req   (token_req)
    );

endmodule

// File: tb/sv/markup_tag_tokenizer_top_test.sv
module markup_tag_tokenizer_top_test;
    import mtt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE0_BYTES = 500;
    localparam int PHASE1_BYTES = 1000;
    localparam int TOTAL_BYTES  = 1850;

    class token_scoreboard;
        scan_mode_t         mode;
        logic [DEPTH_W-1:0] nest;
        int                 depth_limit;
        token_req_t         pending_tokens[$];
        int                 errors;
        int                 token_idx;

        function new(int limit);
            depth_limit = limit;
            errors      = 0;
            token_idx   = 0;
            mode        = M_START;
            nest        = '0;
        endfunction

        function void note_byte(byte_req_t b);
            token_req_t       t;
            logic [EVENT_W-1:0] ev;
            ev = EV_IGNORED;
            case (mode)
                M_START:
                begin
                    if (b.ch == CH_LT)
                        mode = M_ELEM_START;
                end
                M_ELEM_START:
                begin
                    if (b.ch == CH_SLASH)
                    begin
                        if (nest == 0)
                        begin
                            mode = M_END;
                            ev   = EV_DOC_END;
                        end
                        else
                        begin
                            nest = nest - 1'b1;
                            mode = M_CLOSING;
                            ev   = EV_CLOSE;
                        end
                    end
                    else if (int'(nest) >= depth_limit || nest == 8'hFF)
                    begin
                        mode = M_HALT;
                        ev   = EV_OVERFLOW;
                    end
                    else
                    begin
                        nest = nest + 1'b1;
                        mode = M_ELEM;
                        ev   = EV_OPEN;
                    end
                end
                M_ELEM:
                begin
                    if (b.ch == CH_SPACE)
                    begin
                        mode = M_ATTR_NAME;
                        ev   = EV_NAME_END;
                    end
                    else if (b.ch == CH_GT)
                    begin
                        mode = M_ELEM_END;
                        ev   = EV_NAME_TAG;
                    end
                    else
                        ev = EV_NAME_CH;
                end
                M_ATTR_NAME:
                begin
                    if (b.ch == CH_EQ)
                        mode = M_VAL_START;
                    else
                        ev = EV_ANAME_CH;
                end
                M_VAL_START:
                begin
                    if (b.ch == CH_QUOTE)
                        mode = M_VAL;
                end
                M_VAL:
                begin
                    if (b.ch == CH_QUOTE)
                        mode = M_VAL_END;
                    else
                        ev = EV_AVAL_CH;
                end
                M_VAL_END:
                begin
                    if (b.ch == CH_SPACE)
                    begin
                        mode = M_ATTR_NAME;
                        ev   = EV_ATTR;
                    end
                    else if (b.ch == CH_GT)
                    begin
                        mode = M_ELEM_END;
                        ev   = EV_ATTR_TAG;
                    end
                end
                M_ELEM_END:
                begin
                    if (b.ch == CH_LT)
                        mode = M_ELEM_START;
                end
                M_CLOSING:
                begin
                    if (b.ch == CH_GT)
                        mode = M_START;
                end
                default:
                begin
                end
            endcase
            t.event_res = ev;
            t.ch_out    = b.ch;
            t.depth     = nest;
            pending_tokens.push_back(t);
            if (b.last)
            begin
                mode = M_START;
                nest = '0;
            end
        endfunction

        task report(string what, int got, int want);
            $display("token %0d %s: got %0d want %0d", token_idx, what, got, want);
            errors++;
        endtask

        task check_token(token_req_t got);
            token_req_t want;
            if (pending_tokens.size() == 0)
                report("unexpected token, event", got.event_res, 0);
            else
            begin
                want = pending_tokens.pop_front();
                if (got.event_res != want.event_res)
                    report("event_res", got.event_res, want.event_res);
                if (got.ch_out != want.ch_out)
                    report("ch_out", got.ch_out, want.ch_out);
                if (got.depth != want.depth)
                    report("depth", got.depth, want.depth);
            end
            token_idx++;
        endtask
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       byte_valid  = 1'b0;
    logic       byte_stall;
    byte_req_t  byte_req    = '0;
    logic       token_valid;
    logic       token_stall = 1'b0;
    token_req_t token_req;

    int send_idle_pct = 27;
    int recv_idle_pct = 82;
    int bytes_sent    = 0;
    int cycle_cnt     = 0;

    token_scoreboard sb = new(MAX_DEPTH_DEFAULT);

    markup_tag_tokenizer_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_req    (byte_req),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_req   (token_req)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        token_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
        if (rst_n && token_valid && !token_stall)
            sb.check_token(token_req);

    function automatic logic [7:0] rand_byte_not(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == a || v == b);
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] c, logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_req   <= '{ch: c, last: l};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sb.note_byte(byte_req);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s, logic l);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], l && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_tokens.size() != 0);
    endtask

    task automatic open_tag();
        int n_attr;
        int a;
        send_byte(CH_LT, 1'b0);
        send_byte(rand_byte_not(CH_SLASH, CH_SLASH), 1'b0);
        repeat ($urandom_range(0, 4))
            send_byte(rand_byte_not(CH_SPACE, CH_GT), 1'b0);
        n_attr = $urandom_range(0, 2);
        if (n_attr == 0)
            send_byte(CH_GT, 1'b0);
        else
        begin
            send_byte(CH_SPACE, 1'b0);
            for (a = 0; a < n_attr; a++)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(rand_byte_not(CH_EQ, CH_EQ), 1'b0);
                send_byte(CH_EQ, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_byte(rand_byte_not(CH_QUOTE, CH_QUOTE), 1'b0);
                send_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5))
                    send_byte(rand_byte_not(CH_QUOTE, CH_QUOTE), 1'b0);
                send_byte(CH_QUOTE, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_byte(rand_byte_not(CH_SPACE, CH_GT), 1'b0);
                send_byte((a == n_attr - 1) ? CH_GT : CH_SPACE, 1'b0);
            end
        end
    endtask

    task automatic close_tag();
        send_byte(CH_LT, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 3))
            send_byte(rand_byte_not(CH_GT, CH_GT), 1'b0);
        send_byte(CH_GT, 1'b0);
    endtask

    task automatic random_doc();
        int n_steps;
        int k;
        int n_tail;
        n_steps = $urandom_range(4, 40);
        for (k = 0; k < n_steps; k++)
        begin
            case ($urandom_range(0, 9))
                0:
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
                1, 2:
                    repeat ($urandom_range(1, 3))
                        send_byte(rand_byte_not(CH_LT, CH_LT), 1'b0);
                3, 4, 5, 6:
                    if (sb.nest < 20)
                        open_tag();
                    else
                        close_tag();
                default:
                    if (sb.nest != 0)
                        close_tag();
                    else
                        open_tag();
            endcase
        end
        for (k = 0; k < 24 && sb.nest != 0 && sb.mode != M_HALT; k++)
            close_tag();
        n_tail = $urandom_range(0, 2);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_SLASH, n_tail == 0);
        for (k = 0; k < n_tail; k++)
            send_byte(8'($urandom_range(0, 255)), k == n_tail - 1);
    endtask

    // nests to the depth limit, overflows, then feeds the halted scanner
    task automatic deep_doc();
        int k;
        for (k = 0; k < 255; k++)
            send_text("<d>", 1'b0);
        send_text("<x", 1'b0);
        send_text("</ y<", 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("n k=\"v\" q=\"\">", 1'b0);
        send_text("<b></></", 1'b0);
        send_byte(8'h00, 1'b1);

        while (bytes_sent < PHASE0_BYTES)
            random_doc();
        wait_drained();

        send_idle_pct = 82;
        recv_idle_pct = 27;
        while (bytes_sent < PHASE1_BYTES)
            random_doc();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        deep_doc();
        while (bytes_sent < TOTAL_BYTES)
            random_doc();
        wait_drained();
        repeat (6) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
